@@ hw/rtl/dotp_pkg.sv @@
// ----------------------------------------------------------------------------
// DHCP option TLV parser package
// Shared beat types, report codes and tag constants for the parser blocks.
// ----------------------------------------------------------------------------
package dotp_pkg;

  localparam int unsigned DOFF_W      = 11;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] MAGIC_COOKIE_RST = 32'h6382_5363;

  localparam logic [7:0] TAG_PAD      = 8'd0;
  localparam logic [7:0] TAG_END      = 8'd255;
  localparam logic [7:0] TAG_OVERLOAD = 8'd52;

  localparam logic [1:0] AREA_OPTIONS = 2'd0;
  localparam logic [1:0] AREA_FILE    = 2'd1;
  localparam logic [1:0] AREA_SNAME   = 2'd2;

  localparam logic [1:0] KIND_OPTION = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_RAN_OFF   = 2'd2;
  localparam logic [1:0] ST_UNUSED    = 2'd3;

  typedef enum logic [6:0] {
    PH_MAGIC    = 7'b0000001,
    PH_TAG      = 7'b0000010,
    PH_LEN      = 7'b0000100,
    PH_DATA     = 7'b0001000,
    PH_DONE     = 7'b0010000,
    PH_BADMAGIC = 7'b0100000,
    PH_UNUSED   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0] area;
    logic [7:0] data_byte;
    logic       last_in_area;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        report_kind;
    logic [7:0]        option_tag;
    logic [7:0]        option_length;
    logic [DOFF_W-1:0] data_offset;
    logic [1:0]        report_area;
    logic [1:0]        area_status;
    logic [1:0]        overload_mode;
    logic              last_report;
  } out_item_t;

  typedef struct packed {
    out_item_t first;
    out_item_t second;
    logic      two;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

@@ hw/rtl/dhcp_option_tlv_parser_unit.sv @@
// ----------------------------------------------------------------------------
// DHCP option TLV parser
// Parses the options, file and sname areas byte by byte into option reports.
// ----------------------------------------------------------------------------
// A byte's reports are registered in the report queue on acceptance and offered
// from its head. Throughput: one byte per cycle while the queue is not full; a
// byte that closes an area and carries an end tag or option length gives two
// reports, absorbed by a four-entry report queue between parser and output.
// Reset: synchronous; clears the queue and parse state and reloads the cookie.
module dhcp_option_tlv_parser_unit
  import dotp_pkg::*;
#(
  parameter int unsigned MAX_AREA_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic      push, pop, in_accept;
  q_entry_t  push_entry, head;
  q_status_t q_status;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_status.full;
  assign in_accept = in_valid && in_ready;

  dotp_front #(
    .MAX_AREA_BYTES(MAX_AREA_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_data   (in_data),
    .push      (push),
    .push_entry(push_entry)
  );

  dotp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  dotp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

@@ hw/rtl/dotp_front.sv @@
// ----------------------------------------------------------------------------
// DHCP option TLV parser front end
// Runs the per-area parse phase on each accepted byte and builds its reports.
// ----------------------------------------------------------------------------
module dotp_front
  import dotp_pkg::*;
#(
  parameter int unsigned MAX_AREA_BYTES = 2048
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  input  logic [31:0] cfg_data,
  input  logic      in_accept,
  input  in_item_t  in_data,
  output logic      push,
  output q_entry_t  push_entry
);

  localparam int unsigned OFF_W   = $clog2(MAX_AREA_BYTES);
  localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_AREA_BYTES - 1);

  logic [31:0]      cookie_r;
  phase_t           phase_r, phase_nxt, ph_e;
  logic             opening_r, opening_nxt;
  logic [1:0]       run_area_r, area_e;
  logic [1:0]       midx_r, midx_nxt, midx_e;
  logic [7:0]       held_r, held_nxt, held_e;
  logic [7:0]       skip_r, skip_nxt, skip_e;
  logic [OFF_W-1:0] aoff_r, aoff_nxt, aoff_e, off_rep;
  logic [1:0]       ovl_r, ovl_nxt, ovl_e;
  logic             seen_r, seen_nxt, seen_e;
  logic             cap_r, cap_nxt, cap_e;
  logic [7:0]       expect_byte;
  logic [7:0]       b;
  logic             has_a;
  logic [1:0]       st;
  logic [OFF_W+DOFF_W-1:0] off_wide;
  out_item_t        rep_a, rep_s;

  assign b = in_data.data_byte;
  assign off_wide = (OFF_W + DOFF_W)'(off_rep);

  always_comb begin
    area_e = in_data.area;
    ph_e   = PH_UNUSED;
    if (opening_r) begin
      aoff_e = '0;
      midx_e = '0;
      held_e = '0;
      skip_e = '0;
      cap_e  = 1'b0;
      ovl_e  = ovl_r;
      seen_e = seen_r;
      case (in_data.area)
        AREA_OPTIONS: begin
          ovl_e  = '0;
          seen_e = 1'b0;
          ph_e   = PH_MAGIC;
        end
        AREA_FILE:  ph_e = ovl_r[0] ? PH_TAG : PH_UNUSED;
        AREA_SNAME: ph_e = ovl_r[1] ? PH_TAG : PH_UNUSED;
        default:    ph_e = PH_UNUSED;
      endcase
    end else begin
      area_e = run_area_r;
      ph_e   = phase_r;
      aoff_e = aoff_r;
      midx_e = midx_r;
      held_e = held_r;
      skip_e = skip_r;
      cap_e  = cap_r;
      ovl_e  = ovl_r;
      seen_e = seen_r;
    end
  end

  always_comb begin
    case (midx_e)
      2'd0:    expect_byte = cookie_r[31:24];
      2'd1:    expect_byte = cookie_r[23:16];
      2'd2:    expect_byte = cookie_r[15:8];
      default: expect_byte = cookie_r[7:0];
    endcase
  end

  always_comb begin
    off_rep = (aoff_e == OFF_MAX) ? OFF_MAX : aoff_e + OFF_W'(1);
  end

  always_comb begin
    phase_nxt = ph_e;
    midx_nxt  = midx_e;
    held_nxt  = held_e;
    skip_nxt  = skip_e;
    ovl_nxt   = ovl_e;
    seen_nxt  = seen_e;
    cap_nxt   = cap_e;
    has_a     = 1'b0;
    rep_a     = '0;
    rep_a.report_area   = area_e;
    rep_a.overload_mode = ovl_e;
    case (ph_e)
      PH_MAGIC: begin
        if (b != expect_byte) begin
          phase_nxt = PH_BADMAGIC;
        end else if (midx_e == 2'd3) begin
          phase_nxt = PH_TAG;
        end else begin
          midx_nxt = midx_e + 2'd1;
        end
      end
      PH_TAG: begin
        if (b == TAG_END) begin
          has_a = 1'b1;
          rep_a.report_kind = KIND_END;
          rep_a.option_tag  = TAG_END;
          phase_nxt = PH_DONE;
        end else if (b != TAG_PAD) begin
          held_nxt  = b;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        has_a = 1'b1;
        rep_a.report_kind   = KIND_OPTION;
        rep_a.option_tag    = held_e;
        rep_a.option_length = b;
        rep_a.data_offset   = off_wide[DOFF_W-1:0];
        if (area_e == AREA_OPTIONS && held_e == TAG_OVERLOAD && !seen_e) begin
          seen_nxt = 1'b1;
          if (b == 8'd1) begin
            cap_nxt = 1'b1;
          end
        end
        if (b == 8'd0) begin
          phase_nxt = PH_TAG;
        end else begin
          skip_nxt  = b;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (cap_e) begin
          ovl_nxt = (b >= 8'd1 && b <= 8'd3) ? b[1:0] : 2'd0;
          cap_nxt = 1'b0;
        end
        skip_nxt = skip_e - 8'd1;
        if (skip_e == 8'd1) begin
          phase_nxt = PH_TAG;
        end
      end
      default: begin
      end
    endcase

    case (phase_nxt)
      PH_MAGIC, PH_BADMAGIC: st = ST_BAD_MAGIC;
      PH_LEN, PH_DATA:       st = ST_RAN_OFF;
      PH_UNUSED:             st = ST_UNUSED;
      default:               st = ST_OK;
    endcase
    if (in_data.last_in_area && area_e == AREA_OPTIONS && st != ST_OK) begin
      ovl_nxt = '0;
      cap_nxt = 1'b0;
    end

    rep_s = '0;
    rep_s.report_kind   = KIND_STATUS;
    rep_s.report_area   = area_e;
    rep_s.area_status   = st;
    rep_s.overload_mode = ovl_nxt;
    rep_s.last_report   = 1'b1;

    push_entry = '0;
    if (has_a && in_data.last_in_area) begin
      push_entry.first  = rep_a;
      push_entry.second = rep_s;
      push_entry.two    = 1'b1;
    end else if (has_a) begin
      push_entry.first = rep_a;
      push_entry.first.last_report = 1'b1;
    end else begin
      push_entry.first = rep_s;
    end

    aoff_nxt    = (aoff_e < OFF_MAX) ? aoff_e + OFF_W'(1) : aoff_e;
    opening_nxt = in_data.last_in_area;
  end

  assign push = in_accept && (has_a || in_data.last_in_area);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cookie_r   <= MAGIC_COOKIE_RST;
      phase_r    <= PH_MAGIC;
      opening_r  <= 1'b1;
      run_area_r <= '0;
      midx_r     <= '0;
      held_r     <= '0;
      skip_r     <= '0;
      aoff_r     <= '0;
      ovl_r      <= '0;
      seen_r     <= 1'b0;
      cap_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cookie_r <= cfg_data;
      end
      if (in_accept) begin
        phase_r    <= phase_nxt;
        opening_r  <= opening_nxt;
        run_area_r <= area_e;
        midx_r     <= midx_nxt;
        held_r     <= held_nxt;
        skip_r     <= skip_nxt;
        aoff_r     <= aoff_nxt;
        ovl_r      <= ovl_nxt;
        seen_r     <= seen_nxt;
        cap_r      <= cap_nxt;
      end
    end
  end

endmodule

@@ hw/rtl/dotp_queue.sv @@
// ----------------------------------------------------------------------------
// DHCP option TLV parser report queue
// Short first-in first-out buffer of report pairs between front and back.
// ----------------------------------------------------------------------------
module dotp_queue
  import dotp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head    = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/dotp_back.sv @@
// ----------------------------------------------------------------------------
// DHCP option TLV parser back end
// Plays out the one or two reports of each queued byte on the result channel.
// ----------------------------------------------------------------------------
module dotp_back
  import dotp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_status,
  input  q_entry_t  head,
  output logic      pop,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data
);

  logic sel_r, sel_nxt;
  logic out_fire;

  assign out_valid = !q_status.empty;
  assign out_data  = sel_r ? head.second : head.first;
  assign out_fire  = out_valid && out_ready;
  assign pop       = out_fire && (!head.two || sel_r);

  always_comb begin
    sel_nxt = sel_r;
    if (out_fire) begin
      sel_nxt = head.two && !sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

@@ hw/rtl/dotp_checker.sv @@
// ----------------------------------------------------------------------------
// DHCP option TLV parser checker
// Port-level properties of the parser, bound to its top level.
// ----------------------------------------------------------------------------
module dotp_checker
  import dotp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result beat changed while stalled.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.report_kind == KIND_STATUS |-> out_data.last_report)
    else $error("Area status is not the last report of its byte.");

  a_option_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.report_kind == KIND_OPTION |->
      out_data.option_tag != TAG_PAD && out_data.option_tag != TAG_END &&
      out_data.area_status == ST_OK)
    else $error("Malformed option report.");

endmodule

bind dhcp_option_tlv_parser_unit dotp_checker u_dotp_checker (.*);
